/* rtl/dps_pkg.sv */
// shared types and status codes for the dynamic priority scheduler
package dps_pkg;

	typedef struct packed {
		logic [7:0]         id;
		logic [15:0]        run_time;
		logic signed [15:0] prio;
	} entry_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_REQUEUED = 3'd1,
		ST_FINISHED = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	localparam logic [0:0] MODE_ADD  = 1'b0;
	localparam logic [0:0] MODE_TICK = 1'b1;

	localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

endpackage

/* rtl/dps_mem.sv */
// queue storage: one write port, one registered read port
module dps_mem
	import dps_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/dynamic_priority_scheduler_unit.sv */
// dynamic priority scheduler: sequencer, shared compare step and result register
//
// Ready queue of up to MAX_PROCS processes, highest priority at the head, kept
// in a circular buffer in one memory with a registered read port. An add walks
// the queue from the tail, one entry per cycle through a single priority
// comparator, moving each entry of lower or equal priority one place back until
// the new entry's slot is found. A tick reads the head, advances the head
// pointer, decrements priority (saturating) and remaining time, and reinserts
// the process by the same walk when time is left. The memory's single read and
// write port sets one entry moved per cycle. Result items wait in an output
// register and the next item is taken while one is pending.
module dynamic_priority_scheduler_unit
	import dps_pkg::*;
#(
	parameter int MAX_PROCS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [7:0]         proc_id,
	input  logic [15:0]        run_time,
	input  logic signed [15:0] priority_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [7:0]         chosen_id,
	output logic [15:0]        time_left,
	output logic signed [15:0] priority_out
);

	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam int IW = $clog2(MAX_PROCS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_HEAD = 4'b0010,
		S_INS  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   pos_q;
	entry_t          entry_q;
	status_t         res_status_q;

	logic            out_valid_q;
	logic [2:0]      status_q;
	entry_t          out_entry_q;

	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	entry_t          wr_data;
	logic [IW-1:0]   rd_addr;
	entry_t          rd_data;

	logic            in_acc;
	logic            out_free;
	logic            is_full;
	logic            shift_back;
	entry_t          head_dec;
	logic            head_done;
	logic [CW-1:0]   count_m1;
	logic [CW-1:0]   pos_m2;

	// logical queue position to physical slot
	function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [IW-1:0] lg);
		logic [IW:0] s;
		s = {1'b0, hd} + {1'b0, lg};
		if (s >= (IW+1)'(MAX_PROCS)) begin
			s = s - (IW+1)'(MAX_PROCS);
		end
		return s[IW-1:0];
	endfunction

	dps_mem #(
		.DEPTH (MAX_PROCS),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign is_full    = (count_q == CW'(MAX_PROCS));
	assign count_m1   = count_q - CW'(1);
	assign pos_m2     = pos_q - CW'(2);

	// the shared compare: entries at or below the new priority move back
	assign shift_back = ($signed(rd_data.prio) <= $signed(entry_q.prio));

	// head decrement with saturation
	always_comb begin
		head_dec.id = rd_data.id;
		head_dec.prio = (rd_data.prio == PRIO_MIN) ? PRIO_MIN : rd_data.prio - 16'sd1;
		head_done = (rd_data.run_time <= 16'd1);
		head_dec.run_time = head_done ? 16'd0 : rd_data.run_time - 16'd1;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = phys(head_q, pos_q[IW-1:0]);
		wr_data = entry_q;
		rd_addr = phys(head_q, pos_m2[IW-1:0]);
		case (state_q)
			S_IDLE: begin
				if (mode == MODE_ADD) begin
					rd_addr = phys(head_q, count_m1[IW-1:0]);
				end else begin
					rd_addr = head_q;
				end
			end
			S_HEAD: begin
				// tail of the queue after the head leaves
				rd_addr = phys(head_q, count_m1[IW-1:0]);
			end
			S_INS: begin
				wr_en = 1'b1;
				if (pos_q != '0 && shift_back) begin
					wr_data = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (mode == MODE_ADD) begin
							state_q <= is_full ? S_DONE : S_INS;
						end else begin
							state_q <= (count_q == '0) ? S_DONE : S_HEAD;
						end
					end
				end
				S_HEAD: begin
					head_q  <= phys(head_q, IW'(1));
					count_q <= count_m1;
					state_q <= head_done ? S_DONE : S_INS;
				end
				S_INS: begin
					if (pos_q == '0 || !shift_back) begin
						count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					pos_q <= count_q;
					if (mode == MODE_ADD) begin
						entry_q.id       <= proc_id;
						entry_q.run_time <= run_time;
						entry_q.prio     <= priority_in;
						res_status_q     <= is_full ? ST_FULL : ST_ADDED;
					end else begin
						entry_q      <= '0;
						res_status_q <= ST_EMPTY;
					end
				end
			end
			S_HEAD: begin
				entry_q      <= head_dec;
				pos_q        <= count_m1;
				res_status_q <= head_done ? ST_FINISHED : ST_REQUEUED;
			end
			S_INS: begin
				if (pos_q != '0 && shift_back) begin
					pos_q <= pos_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q    <= res_status_q;
			out_entry_q <= entry_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign chosen_id    = out_entry_q.id;
	assign time_left    = out_entry_q.run_time;
	assign priority_out = out_entry_q.prio;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PROCS))
		else $error("queue count beyond capacity");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> (count_q < CW'(MAX_PROCS)))
		else $error("insert walk started on a full queue");

	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && mode == MODE_ADD && is_full) |=>
			(state_q == S_DONE && res_status_q == ST_FULL && $stable(count_q)))
		else $error("add to full queue not reported");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result item raised outside completion");

	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HEAD) |=> (count_q == $past(count_m1)))
		else $error("tick did not remove the head entry");
`endif

endmodule

/* verif/tb_dynamic_priority_scheduler_unit.sv */
// self-checking testbench for the dynamic priority scheduler unit
module tb_dynamic_priority_scheduler_unit;
	import dps_pkg::*;

	localparam int MAX_PROCS      = 8;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_ITEMS    = 128;
	localparam int PRINT_LIMIT    = 40;

	typedef struct packed {
		logic [0:0]         mode;
		logic [7:0]         id;
		logic [15:0]        rt;
		logic signed [15:0] prio;
	} request_t;

	typedef struct packed {
		status_t            st;
		logic [7:0]         id;
		logic [15:0]        tl;
		logic signed [15:0] pr;
	} outcome_t;

	// slot 0 is the head of the ready queue
	typedef struct packed {
		entry_t [MAX_PROCS-1:0] slot;
		logic [7:0]             count;
	} ready_q_t;

	typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_t;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic               mode         = MODE_ADD;
	logic [7:0]         proc_id      = 8'd0;
	logic [15:0]        run_time     = 16'd0;
	logic signed [15:0] priority_in  = 16'sd0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [2:0]         status;
	logic [7:0]         chosen_id;
	logic [15:0]        time_left;
	logic signed [15:0] priority_out;

	request_t request_q[$];
	outcome_t due_results[$];
	ready_q_t live_q;
	ready_q_t plan_q;
	request_t nxt;
	bit       item_taken  = 1'b0;
	int       n_taken     = 0;
	int       err_count   = 0;
	int       idle_cycles = 0;

	dynamic_priority_scheduler_unit #(
		.MAX_PROCS(MAX_PROCS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.proc_id(proc_id),
		.run_time(run_time),
		.priority_in(priority_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.chosen_id(chosen_id),
		.time_left(time_left),
		.priority_out(priority_out)
	);

	task automatic insert_entry(inout ready_q_t rq, input entry_t e);
		int pos;
		pos = 0;
		// ahead of the first entry of lower or equal priority
		while (pos < rq.count && e.prio < rq.slot[pos].prio)
			pos = pos + 1;
		for (int i = MAX_PROCS - 1; i > pos; i--)
			rq.slot[i] = rq.slot[i-1];
		rq.slot[pos] = e;
		rq.count = rq.count + 1;
	endtask

	task automatic serve_request(inout ready_q_t rq, input request_t r, output outcome_t o);
		entry_t head;
		entry_t fresh;
		o.st = ST_EMPTY;
		o.id = 8'd0;
		o.tl = 16'd0;
		o.pr = 16'sd0;
		if (r.mode == MODE_ADD) begin
			o.id = r.id;
			o.tl = r.rt;
			o.pr = r.prio;
			if (rq.count >= MAX_PROCS) begin
				o.st = ST_FULL;
			end else begin
				o.st = ST_ADDED;
				fresh.id = r.id;
				fresh.run_time = r.rt;
				fresh.prio = r.prio;
				insert_entry(rq, fresh);
			end
		end else if (rq.count != 0) begin
			head = rq.slot[0];
			for (int i = 1; i < MAX_PROCS; i++)
				rq.slot[i-1] = rq.slot[i];
			rq.count = rq.count - 1;
			if (head.prio != PRIO_MIN)
				head.prio = head.prio - 16'sd1;
			if (head.run_time <= 16'd1) begin
				head.run_time = 16'd0;
				o.st = ST_FINISHED;
			end else begin
				head.run_time = head.run_time - 16'd1;
				o.st = ST_REQUEUED;
				insert_entry(rq, head);
			end
			o.id = head.id;
			o.tl = head.run_time;
			o.pr = head.prio;
		end
	endtask

	task automatic queue_request(input logic [0:0] m, input logic [7:0] id,
			input logic [15:0] rt, input logic signed [15:0] pr);
		request_t r;
		outcome_t unused;
		r.mode = m;
		r.id = id;
		r.rt = rt;
		r.prio = pr;
		request_q.push_back(r);
		serve_request(plan_q, r, unused);
	endtask

	task automatic note_mismatch(input string msg);
		if (err_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
		err_count = err_count + 1;
	endtask

	function automatic bit roll(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic int sender_idle_pct(input int n);
		case ((n / PHASE_ITEMS) % 4)
			1: return 45;
			3: return 16;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct(input int n);
		case ((n / PHASE_ITEMS) % 4)
			2: return 45;
			3: return 16;
			default: return 0;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: hold the item until taken, then load the next one or idle
	always @(negedge clk) begin
		if (in_valid && !item_taken) begin
		end else if (arst_n && request_q.size() != 0 && !roll(sender_idle_pct(n_taken))) begin
			nxt = request_q.pop_front();
			in_valid <= 1'b1;
			mode <= nxt.mode;
			proc_id <= nxt.id;
			run_time <= nxt.rt;
			priority_in <= nxt.prio;
		end else begin
			in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && roll(receiver_stall_pct(n_taken));
	end

	always @(posedge clk) begin : monitor
		outcome_t want;
		request_t got;
		item_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				got.mode = mode;
				got.id = proc_id;
				got.rt = run_time;
				got.prio = priority_in;
				serve_request(live_q, got, want);
				due_results.push_back(want);
				n_taken <= n_taken + 1;
			end
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					note_mismatch("result with none expected");
				end else begin
					want = due_results.pop_front();
					if (status !== want.st)
						note_mismatch($sformatf("status %0d, expected %0d", status, want.st));
					if (chosen_id !== want.id)
						note_mismatch($sformatf("chosen_id %0d, expected %0d",
							chosen_id, want.id));
					if (time_left !== want.tl)
						note_mismatch($sformatf("time_left %0d, expected %0d",
							time_left, want.tl));
					if (priority_out !== want.pr)
						note_mismatch($sformatf("priority_out %0d, expected %0d",
							priority_out, want.pr));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("dynamic_priority_scheduler_unit regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		burst_t kind;
		int     burst_len;
		int     add_pct;
		int     made;
		int     pv;
		logic [15:0] rt;
		logic signed [15:0] pr;
		live_q = '0;
		plan_q = '0;

		// corner cases from an empty queue
		queue_request(MODE_TICK, 8'h5a, 16'h1234, 16'sh0123);
		queue_request(MODE_ADD, 8'd0, 16'd0, 16'sd0);
		queue_request(MODE_TICK, 8'd0, 16'd0, 16'sd0);
		queue_request(MODE_ADD, 8'd255, 16'd1, 16'sh7fff);
		queue_request(MODE_ADD, 8'd1, 16'd3, PRIO_MIN);
		queue_request(MODE_ADD, 8'd2, 16'd2, PRIO_MIN);
		queue_request(MODE_TICK, 8'hff, 16'hffff, 16'shffff);
		// priority stuck at its minimum, equal priorities newest first
		repeat (6) queue_request(MODE_TICK, 8'h00, 16'h0000, 16'sh0000);
		// fill to capacity with ties, then add to a full queue
		for (int i = 0; i < MAX_PROCS; i++)
			queue_request(MODE_ADD, 8'(8'd10 + i), 16'(2 + i % 3), 16'(i % 3 - 1));
		queue_request(MODE_ADD, 8'hff, 16'hffff, 16'sh7fff);
		queue_request(MODE_ADD, 8'haa, 16'h5555, PRIO_MIN);
		queue_request(MODE_TICK, 8'h55, 16'haaaa, 16'sh2aaa);

		made = 0;
		while (made < RANDOM_ITEMS) begin
			kind = burst_t'($urandom_range(2, 0));
			burst_len = $urandom_range(30, 5);
			add_pct = (kind == BURST_FILL) ? 80 : (kind == BURST_DRAIN) ? 20 : 50;
			for (int j = 0; j < burst_len && made < RANDOM_ITEMS; j++) begin
				if (roll(add_pct)) begin
					if (plan_q.count >= MAX_PROCS) begin
						// rejected anyway, so any run time is safe here
						queue_request(MODE_ADD, 8'($urandom), 16'($urandom), 16'($urandom));
					end else begin
						if (RANDOM_ITEMS - made < 40 && roll(10))
							rt = 16'($urandom);
						else if (roll(85))
							rt = 16'($urandom_range(4, 0));
						else
							rt = 16'($urandom_range(12, 5));
						pv = $urandom_range(99, 0);
						if (pv < 40)
							pr = 16'(int'($urandom_range(4, 0)) - 2);
						else if (pv < 60)
							pr = PRIO_MIN + 16'($urandom_range(2, 0));
						else if (pv < 70)
							pr = 16'sh7fff - 16'($urandom_range(2, 0));
						else
							pr = 16'($urandom);
						queue_request(MODE_ADD, 8'($urandom), rt, pr);
					end
				end else begin
					queue_request(MODE_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
				end
				made = made + 1;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (due_results.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", due_results.size()));
		if (err_count == 0)
			$display("dynamic_priority_scheduler_unit regression: pass");
		else
			$display("dynamic_priority_scheduler_unit regression: fail");
		$finish;
	end

endmodule
